### design/lps_pkg.sv
package lps_pkg;

    // Pattern mode codes.
    typedef logic [2:0] mode_t;

    localparam mode_t MODE_INVERT       = 3'd1;
    localparam mode_t MODE_FILL_UP      = 3'd2;
    localparam mode_t MODE_FILL_DOWN    = 3'd3;
    localparam mode_t MODE_HALF_EDGES   = 3'd4;
    localparam mode_t MODE_HALF_CENTER  = 3'd5;
    localparam mode_t MODE_STACK_TOP    = 3'd6;
    localparam mode_t MODE_STACK_BOTTOM = 3'd7;

    localparam mode_t MODE_MIN = MODE_INVERT;
    localparam mode_t MODE_MAX = MODE_STACK_BOTTOM;

    localparam int LED_COUNT = 32;
    localparam int CNT_W     = 6;
    localparam int TICK_W    = 16;

    localparam logic [TICK_W-1:0] TICKS_PER_FRAME_RESET = 16'd100;

    // Working pattern and the two sequence counters travel together.
    typedef struct packed {
        logic [LED_COUNT-1:0] work;
        logic [CNT_W-1:0]     outer;
        logic [CNT_W-1:0]     dot;
    } frame_state_t;

endpackage

### design/lps_debounce.sv
module lps_debounce #(
    parameter int LEN = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic level,
    output logic press
);

    localparam logic [LEN-1:0] FIRE_PATTERN = {1'b1, {(LEN-1){1'b0}}};

    logic [LEN-1:0] history_reg;
    logic [LEN-1:0] history_next;

    // One released sample followed by LEN-1 pressed samples is a press.
    assign history_next = {history_reg[LEN-2:0], level};
    assign press        = en && (history_next == FIRE_PATTERN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= '0;
        end
        else if (en)
        begin
            history_reg <= history_next;
        end
    end

endmodule

### design/lps_frame.sv
module lps_frame (
    input  lps_pkg::mode_t        mode,
    input  lps_pkg::frame_state_t cur,
    output lps_pkg::frame_state_t nxt
);

    import lps_pkg::*;

    logic        fill_bit;
    logic        half_bit;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [5:0]  half_outer;

    // Stacking search state, up to four narrow steps.
    logic [5:0]  so;
    logic [5:0]  sd;
    logic        hit;
    logic [4:0]  hit_o;
    logic [4:0]  hit_d;
    logic [31:0] stack_top;
    logic [31:0] stack_bottom;

    assign fill_bit   = (cur.outer < 6'd32);
    assign half_bit   = (cur.outer < 6'd16);
    assign lo         = cur.work[15:0];
    assign hi         = cur.work[31:16];
    assign half_outer = (cur.outer == 6'd31) ? 6'd0 : cur.outer + 6'd1;

    always_comb
    begin
        so    = cur.outer;
        sd    = cur.dot;
        hit   = 1'b0;
        hit_o = '0;
        hit_d = '0;
        for (int g = 0; g < 4; g++)
        begin
            if (!hit)
            begin
                if (so >= 6'd32)
                begin
                    so = '0;
                end
                else if (sd >= 6'd32 - so)
                begin
                    sd = '0;
                    so = so + 6'd1;
                end
                else
                begin
                    hit   = 1'b1;
                    hit_o = so[4:0];
                    hit_d = sd[4:0];
                    sd    = sd + 6'd1;
                end
            end
        end
    end

    assign stack_top    = ~(32'hffff_ffff >> hit_o) | (32'h0000_0001 << hit_d);
    assign stack_bottom = ~(32'hffff_ffff << hit_o) | (32'h8000_0000 >> hit_d);

    always_comb
    begin
        nxt = cur;
        unique case (mode)
            MODE_INVERT:
            begin
                nxt.work = ~cur.work;
            end
            MODE_FILL_UP:
            begin
                nxt.work  = {cur.work[30:0], fill_bit};
                nxt.outer = cur.outer + 6'd1;
            end
            MODE_FILL_DOWN:
            begin
                nxt.work  = {fill_bit, cur.work[31:1]};
                nxt.outer = cur.outer + 6'd1;
            end
            MODE_HALF_EDGES:
            begin
                nxt.work  = {half_bit, hi[15:1], lo[14:0], half_bit};
                nxt.outer = half_outer;
            end
            MODE_HALF_CENTER:
            begin
                nxt.work  = {hi[14:0], half_bit, half_bit, lo[15:1]};
                nxt.outer = half_outer;
            end
            MODE_STACK_TOP, MODE_STACK_BOTTOM:
            begin
                nxt.outer = so;
                nxt.dot   = sd;
                if (hit)
                begin
                    nxt.work = (mode == MODE_STACK_TOP) ? stack_top : stack_bottom;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### design/led32_pattern_sequencer.sv
// 32-LED pattern sequencer. Each input transaction is one millisecond tick carrying the
// raw levels of the up, down and clear buttons (1 released, 0 pressed); each tick gives
// exactly one output transaction with the latched LED word, the pattern mode after the
// tick and a strobe that marks a newly latched frame. Buttons are debounced over
// DEBOUNCE_LEN samples, and a press steps the mode between 1 and 7 and restarts the
// pattern. A frame is latched every ticks_per_frame ticks (zero acts as one), written
// through the configuration channel while no ticks are in flight. The block takes one
// tick per clock while the output side is not stalled; a tick goes through an input
// register and the state update into the output register, where its result waits until
// the output side takes it. A stall on the output holds the pipeline, and in_stall rises
// once the input register also holds a tick, so the block buffers at most two ticks.
module led32_pattern_sequencer #(
    parameter int DEBOUNCE_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        up_level,
    input  logic        down_level,
    input  logic        clear_level,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] led_word,
    output logic [2:0]  pattern_mode,
    output logic        frame_strobe,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] ticks_per_frame
);

    import lps_pkg::*;

    // Input register stage.
    logic        s1_valid_reg;
    logic        up_reg;
    logic        down_reg;
    logic        clear_reg;

    // Output register stage and block state.
    logic         out_valid_reg;
    logic         strobe_reg;
    logic [31:0]  shown_reg;
    mode_t        mode_reg;
    frame_state_t frame_state_reg;
    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] period_reg;

    logic         out_free;
    logic         advance;
    logic         in_accept;

    logic         up_press;
    logic         down_press;
    logic         clear_press;
    logic         any_press;

    mode_t        mode_next;
    frame_state_t pressed_state;
    frame_state_t stepped_state;
    frame_state_t frame_state_next;
    logic [31:0]  shown_next;
    logic [TICK_W-1:0] period;
    logic [TICK_W:0]   tick_sum;
    logic         frame_fire;
    logic [TICK_W-1:0] tick_count_next;

    // The output register can take a new result when it is empty or being taken.
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // Always writable; the user must write only while the block is idle (unenforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= TICKS_PER_FRAME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            period_reg <= ticks_per_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            up_reg    <= up_level;
            down_reg  <= down_level;
            clear_reg <= clear_level;
        end
    end

    lps_debounce #(.LEN(DEBOUNCE_LEN)) u_up_debounce (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .level (up_reg),
        .press (up_press)
    );

    lps_debounce #(.LEN(DEBOUNCE_LEN)) u_down_debounce (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .level (down_reg),
        .press (down_press)
    );

    lps_debounce #(.LEN(DEBOUNCE_LEN)) u_clear_debounce (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .level (clear_reg),
        .press (clear_press)
    );

    assign any_press = up_press || down_press || clear_press;

    // Presses apply in the order up, down, clear; clear wins outright.
    always_comb
    begin
        mode_next = mode_reg;
        if (up_press && (mode_next != MODE_MAX))
        begin
            mode_next = mode_next + 3'd1;
        end
        if (down_press && (mode_next != MODE_MIN))
        begin
            mode_next = mode_next - 3'd1;
        end
        if (clear_press)
        begin
            mode_next = MODE_MIN;
        end
    end

    // Any press restarts the pattern before the frame step of the same tick.
    assign pressed_state = any_press ? '0 : frame_state_reg;

    lps_frame u_frame (
        .mode (mode_next),
        .cur  (pressed_state),
        .nxt  (stepped_state)
    );

    // Frame timer: a frame fires when the incremented count reaches the period.
    assign period          = (period_reg == '0) ? TICK_W'(1) : period_reg;
    assign tick_sum        = {1'b0, tick_count_reg} + (TICK_W + 1)'(1);
    assign frame_fire      = (tick_sum >= {1'b0, period});
    assign tick_count_next = frame_fire ? '0 : tick_sum[TICK_W-1:0];

    assign frame_state_next = frame_fire ? stepped_state : pressed_state;
    assign shown_next       = frame_fire ? stepped_state.work : shown_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            strobe_reg      <= 1'b0;
            shown_reg       <= '0;
            mode_reg        <= MODE_MIN;
            frame_state_reg <= '0;
            tick_count_reg  <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (advance)
            begin
                strobe_reg      <= frame_fire;
                shown_reg       <= shown_next;
                mode_reg        <= mode_next;
                frame_state_reg <= frame_state_next;
                tick_count_reg  <= tick_count_next;
            end
        end
    end

    // The shown pattern and the mode are state that change only when a result loads.
    assign out_valid    = out_valid_reg;
    assign led_word     = shown_reg;
    assign pattern_mode = mode_reg;
    assign frame_strobe = strobe_reg;

endmodule

### design/lps_checker.sv
module lps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] led_word,
    input logic [2:0]  pattern_mode,
    input logic        frame_strobe
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(led_word)
            && $stable(pattern_mode) && $stable(frame_strobe))
        else $error("stalled result changed");

    // The mode saturates and never reaches zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pattern_mode != 3'd0)
        else $error("pattern mode left its range");

    // An accepted tick leads to a valid result once it has passed the input and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 out_valid)
        else $error("result missing after accepted tick");

    // A new result appears only after an accepted tick has passed the input and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a tick");

    // Input back-pressure comes only from a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

endmodule

bind led32_pattern_sequencer lps_checker u_lps_checker (.*);
